// ===== design/bucket_pool_manager_unit_macros.svh =====
// Assertion macros for the bucket pool manager.
// Used by bucket_pool_manager_unit.sv; expects clk_i and rst_ni in scope.
`ifndef BUCKET_POOL_MANAGER_UNIT_MACROS_SVH
`define BUCKET_POOL_MANAGER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define BPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bucket pool manager check failed");
`define BPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bucket pool manager sequencing check failed");
`else
`define BPM_ASSERT(lbl, prop)
`define BPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/bpm_pkg.sv =====
// Package for the bucket pool manager: sizes, codes and transfer structs.
// No dependencies; used by bucket_pool_manager_unit.
package bpm_pkg;

  localparam int NUM_BUCKETS  = 8;
  localparam int BUCKET_DEPTH = 64;
  localparam int ELEMENT_BITS = 32;
  localparam int MAX_RUN      = 16;

  localparam int BUCKET_AW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_AW     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int STORE_AW    = BUCKET_AW + SLOT_AW;
  localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
  localparam int FILL_W      = 7;
  localparam int CAP_W       = 7;

  localparam logic [2:0] KIND_ACQ_RD   = 3'd0;
  localparam logic [2:0] KIND_ACQ_WR   = 3'd1;
  localparam logic [2:0] KIND_RELEASE  = 3'd2;
  localparam logic [2:0] KIND_WR_BEGIN = 3'd3;
  localparam logic [2:0] KIND_WR_DATA  = 3'd4;
  localparam logic [2:0] KIND_READ     = 3'd5;
  localparam logic [2:0] KIND_QUERY    = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BUCKET = 2'd1;
  localparam logic [1:0] ST_NO_ROOM   = 2'd2;
  localparam logic [1:0] ST_NO_DATA   = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  bucket_index;
    logic [4:0]  item_count;
    logic [31:0] element_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  granted_bucket;
    logic [31:0] element_out;
    logic        last;
    logic [6:0]  items_held;
  } out_t;

endpackage

// ===== design/bpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/bucket_pool_manager_unit.sv =====
// Bucket pool manager: LIFO buckets, read/write grant counters, APB capacity reg.
// Depends on bpm_pkg, bpm_ram and bucket_pool_manager_unit_macros.svh.
// Most kinds give one registered result from S_EXEC; acquires with a nonzero counter
// scan buckets in S_SCAN from 0 up; reads alternate S_RADDR and S_REMIT per element.
// Throughput: busy_o drops as the last result shows, so the next transfer is taken then.
// Reset at once clears flags, fills, rd_cnt; wr_cnt = NUM_BUCKETS; store not cleared.
`include "bucket_pool_manager_unit_macros.svh"

module bucket_pool_manager_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bpm_pkg::in_t  item_i,
  output logic          done_o,
  output bpm_pkg::out_t result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bpm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_RADDR, S_REMIT} state_e;

  state_e                 state_q, state_d;
  in_t                    item_q;
  logic [NUM_BUCKETS-1:0] busy_q, busy_d;
  logic [FILL_W-1:0]      fill_q [NUM_BUCKETS];
  logic [FILL_W-1:0]      fill_d [NUM_BUCKETS];
  logic [CNT_W-1:0]       rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  logic [4:0]             pend_n_q, pend_n_d;
  logic [BUCKET_AW-1:0]   pend_b_q, pend_b_d;
  logic [CAP_W-1:0]       cap_q;
  logic [BUCKET_AW-1:0]   scan_q, scan_d;
  logic [SLOT_AW-1:0]     rptr_q, rptr_d;
  logic [4:0]             rleft_q, rleft_d;
  out_t                   res_q, res_d;
  logic                   done_q, done_d;

  logic [CAP_W-1:0]  eff_cap;
  logic [BUCKET_AW-1:0] idx;
  logic [FILL_W-1:0] fill_sel, pfill, sfill, room, base;
  logic              want_rd, fits, accept, cfg_wr;
  logic              ram_we;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] c);
    return (c != '0) ? c - 1'b1 : c;
  endfunction

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
    return (c < CNT_W'(NUM_BUCKETS)) ? c + 1'b1 : c;
  endfunction

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign done_o   = done_q;
  assign result_o = res_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_q} : 32'd0;

  assign eff_cap  = (cap_q > CAP_W'(BUCKET_DEPTH)) ? CAP_W'(BUCKET_DEPTH) : cap_q;
  assign idx      = item_q.bucket_index;
  assign fill_sel = fill_q[idx];
  assign pfill    = fill_q[pend_b_q];
  assign room     = (fill_sel < eff_cap) ? eff_cap - fill_sel : '0;
  assign base     = fill_sel - {2'b00, item_q.item_count};

  // shared scan compare
  assign want_rd = (item_q.kind == KIND_ACQ_RD);
  assign sfill   = fill_q[scan_q];
  assign fits    = !busy_q[scan_q] && (want_rd ? (sfill != '0) : (sfill < eff_cap));

  assign ram_we    = (state_q == S_EXEC) && (item_q.kind == KIND_WR_DATA) &&
                     (pend_n_q != '0) && (pfill < eff_cap);
  assign ram_waddr = {pend_b_q, pfill[SLOT_AW-1:0]};
  assign ram_raddr = {idx, rptr_q};

  bpm_ram #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(item_q.element_in[ELEMENT_BITS-1:0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    busy_d   = busy_q;
    fill_d   = fill_q;
    rd_cnt_d = rd_cnt_q;
    wr_cnt_d = wr_cnt_q;
    pend_n_d = pend_n_q;
    pend_b_d = pend_b_q;
    scan_d   = scan_q;
    rptr_d   = rptr_q;
    rleft_d  = rleft_q;
    res_d    = '0;
    res_d.last = 1'b1;
    done_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (item_q.kind)
          KIND_ACQ_RD, KIND_ACQ_WR: begin
            if ((want_rd ? rd_cnt_q : wr_cnt_q) == '0) begin
              res_d.status = ST_NO_BUCKET;
            end else begin
              done_d  = 1'b0;
              scan_d  = '0;
              state_d = S_SCAN;
            end
          end
          KIND_WR_DATA: begin
            res_d.items_held = pfill;
            if (pend_n_q == '0) begin
              res_d.status = ST_NO_ROOM;
            end else if (pfill >= eff_cap) begin
              pend_n_d     = '0;
              res_d.status = ST_NO_ROOM;
            end else begin
              fill_d[pend_b_q] = pfill + 1'b1;
              pend_n_d         = pend_n_q - 1'b1;
              res_d.items_held = pfill + 1'b1;
            end
          end
          KIND_RELEASE: begin
            if (fill_sel != '0) rd_cnt_d = inc_sat(rd_cnt_q);
            if (fill_sel < eff_cap) wr_cnt_d = inc_sat(wr_cnt_q);
            busy_d[idx]      = 1'b0;
            res_d.items_held = fill_sel;
          end
          KIND_WR_BEGIN: begin
            res_d.items_held = fill_sel;
            if (room >= {2'b00, item_q.item_count}) begin
              pend_n_d = item_q.item_count;
              pend_b_d = idx;
            end else begin
              pend_n_d     = '0;
              res_d.status = ST_NO_ROOM;
            end
          end
          KIND_READ: begin
            res_d.items_held = fill_sel;
            if ((item_q.item_count > 5'(MAX_RUN)) ||
                ({2'b00, item_q.item_count} > fill_sel)) begin
              res_d.status = ST_NO_DATA;
            end else if (item_q.item_count != '0) begin
              done_d      = 1'b0;
              fill_d[idx] = base;
              rptr_d      = base[SLOT_AW-1:0];
              rleft_d     = item_q.item_count;
              state_d     = S_RADDR;
            end
          end
          default: begin
            res_d.items_held = fill_sel;
          end
        endcase
      end
      S_SCAN: begin
        if (fits) begin
          if (want_rd) begin
            rd_cnt_d = dec_sat(rd_cnt_q);
            if (sfill < eff_cap) wr_cnt_d = dec_sat(wr_cnt_q);
          end else begin
            wr_cnt_d = dec_sat(wr_cnt_q);
            if (sfill != '0) rd_cnt_d = dec_sat(rd_cnt_q);
          end
          busy_d[scan_q]       = 1'b1;
          res_d.granted_bucket = scan_q;
          res_d.items_held     = sfill;
          done_d               = 1'b1;
          state_d              = S_IDLE;
        end else if (scan_q == BUCKET_AW'(NUM_BUCKETS - 1)) begin
          res_d.status = ST_NO_BUCKET;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_RADDR: begin
        state_d = S_REMIT;
      end
      S_REMIT: begin
        done_d            = 1'b1;
        res_d.element_out = 32'(ram_rdata);
        res_d.items_held  = fill_sel;
        res_d.last        = (rleft_q == 5'd1);
        if (rleft_q == 5'd1) begin
          state_d = S_IDLE;
        end else begin
          rleft_d = rleft_q - 1'b1;
          rptr_d  = rptr_q + 1'b1;
          state_d = S_RADDR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      busy_q   <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) fill_q[i] <= '0;
      rd_cnt_q <= '0;
      wr_cnt_q <= CNT_W'(NUM_BUCKETS);
      pend_n_q <= '0;
      pend_b_q <= '0;
      cap_q    <= CAP_RESET;
      scan_q   <= '0;
      rptr_q   <= '0;
      rleft_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      fill_q   <= fill_d;
      rd_cnt_q <= rd_cnt_d;
      wr_cnt_q <= wr_cnt_d;
      pend_n_q <= pend_n_d;
      pend_b_q <= pend_b_d;
      scan_q   <= scan_d;
      rptr_q   <= rptr_d;
      rleft_q  <= rleft_d;
      done_q   <= done_d;
      if (cfg_wr) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      item_q <= item_i;
    end
  end

  `BPM_ASSERT(a_counts_bounded, (rd_cnt_q <= CNT_W'(NUM_BUCKETS)) && (wr_cnt_q <= CNT_W'(NUM_BUCKETS)))
  `BPM_ASSERT_NEXT(a_accept_busy, accept, busy_o)
  `BPM_ASSERT(a_last_ends_item, (done_o && res_q.last) |-> !busy_o)
  `BPM_ASSERT(a_more_follows, (done_o && !res_q.last) |-> (busy_o && (res_q.status == ST_OK)))

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for bucket_pool_manager_unit: a directed table of corner cases,
// then random acquire/write/read/release flows over several capacity settings.
// Depends on bpm_pkg and the RTL only; every result is predicted in-bench and checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpm_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam logic [2:0] CAP_ADDR   = 3'(REG_CAPACITY) << 2;

  typedef struct packed {
    in_t  item;
    logic has_want;
    out_t want;
  } step_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  in_t         item_i  = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy_o, done_o, pready;
  out_t        result_o;
  logic [31:0] prdata;

  bucket_pool_manager_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // pool state as the bench sees it
  logic        bkt_busy [NUM_BUCKETS];
  int unsigned bkt_fill [NUM_BUCKETS];
  logic [31:0] bkt_mem  [NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned n_readable, n_writable, wr_pending, wr_bucket, capacity;
  logic        grant_ok;
  int unsigned grant_idx;

  out_t        due_results [$];
  out_t        head;
  int unsigned items_sent, results_checked, mismatches, burst_left, n_settings;

  step_t dir_tab [23] = '{
    '{'{KIND_QUERY,    3'd0, 5'd0,  32'h0},         1'b1, '{ST_OK,        3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_ACQ_RD,   3'd7, 5'd31, 32'hFFFF_FFFF}, 1'b1, '{ST_NO_BUCKET, 3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_WR_DATA,  3'd0, 5'd0,  32'hDEAD_BEEF}, 1'b1, '{ST_NO_ROOM,   3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_READ,     3'd5, 5'd0,  32'h0},         1'b1, '{ST_OK,        3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_READ,     3'd3, 5'd1,  32'h0},         1'b1, '{ST_NO_DATA,   3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_ACQ_WR,   3'd0, 5'd0,  32'h0},         1'b1, '{ST_OK,        3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_WR_BEGIN, 3'd0, 5'd4,  32'h0},         1'b0, '0},
    '{'{KIND_WR_DATA,  3'd0, 5'd0,  32'hFFFF_FFFF}, 1'b0, '0},
    '{'{KIND_WR_DATA,  3'd0, 5'd0,  32'h0},         1'b0, '0},
    '{'{KIND_WR_DATA,  3'd0, 5'd0,  32'h8000_0001}, 1'b0, '0},
    '{'{KIND_WR_DATA,  3'd0, 5'd0,  32'h1234_5678}, 1'b0, '0},
    '{'{KIND_WR_BEGIN, 3'd1, 5'd31, 32'h0},         1'b0, '0},
    '{'{KIND_WR_BEGIN, 3'd7, 5'd0,  32'h0},         1'b0, '0},
    '{'{KIND_WR_DATA,  3'd7, 5'd31, 32'h5555_5555}, 1'b1, '{ST_NO_ROOM,   3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_READ,     3'd0, 5'd17, 32'h0},         1'b1, '{ST_NO_DATA,   3'd0, 32'h0, 1'b1, 7'd4}},
    '{'{KIND_READ,     3'd0, 5'd31, 32'h0},         1'b1, '{ST_NO_DATA,   3'd0, 32'h0, 1'b1, 7'd4}},
    '{'{KIND_READ,     3'd0, 5'd3,  32'h0},         1'b0, '0},
    '{'{KIND_RELEASE,  3'd0, 5'd0,  32'h0},         1'b0, '0},
    '{'{KIND_ACQ_RD,   3'd0, 5'd0,  32'h0},         1'b1, '{ST_OK,        3'd0, 32'h0, 1'b1, 7'd1}},
    '{'{KIND_SPARE,    3'd7, 5'd31, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,        3'd0, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_RELEASE,  3'd2, 5'd0,  32'h0},         1'b0, '0},
    '{'{KIND_ACQ_WR,   3'd0, 5'd0,  32'h0},         1'b1, '{ST_OK,        3'd1, 32'h0, 1'b1, 7'd0}},
    '{'{KIND_WR_BEGIN, 3'd0, 5'd5,  32'h0},         1'b0, '0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_capacity();
    return (capacity > BUCKET_DEPTH) ? BUCKET_DEPTH : capacity;
  endfunction

  function automatic out_t res(logic [1:0] st, int unsigned g, logic [31:0] e, logic l,
                               int unsigned held);
    out_t r;
    r.status         = st;
    r.granted_bucket = 3'(g);
    r.element_out    = e;
    r.last           = l;
    r.items_held     = 7'(held);
    return r;
  endfunction

  function automatic void advance_pool(in_t it);
    int unsigned cap, n, b, f, room, i;
    logic        want_rd, fits;
    cap      = eff_capacity();
    n        = 32'(it.item_count);
    b        = 32'(it.bucket_index);
    f        = bkt_fill[b];
    grant_ok = 1'b0;
    case (it.kind)
      KIND_ACQ_RD, KIND_ACQ_WR: begin
        want_rd = (it.kind == KIND_ACQ_RD);
        if ((want_rd ? n_readable : n_writable) != 0) begin
          for (i = 0; i < NUM_BUCKETS; i++) begin
            fits = want_rd ? (bkt_fill[i] > 0) : (bkt_fill[i] < cap);
            if (!grant_ok && !bkt_busy[i] && fits) begin
              grant_ok  = 1'b1;
              grant_idx = i;
            end
          end
        end
        if (grant_ok) begin
          f = bkt_fill[grant_idx];
          if ((want_rd || f > 0) && n_readable > 0) n_readable--;
          if ((!want_rd || f < cap) && n_writable > 0) n_writable--;
          bkt_busy[grant_idx] = 1'b1;
          due_results.push_back(res(ST_OK, grant_idx, '0, 1'b1, f));
        end else begin
          due_results.push_back(res(ST_NO_BUCKET, 0, '0, 1'b1, 0));
        end
      end
      KIND_WR_DATA: begin
        f = bkt_fill[wr_bucket];
        if (wr_pending == 0) begin
          due_results.push_back(res(ST_NO_ROOM, 0, '0, 1'b1, f));
        end else if (f >= cap) begin
          wr_pending = 0;
          due_results.push_back(res(ST_NO_ROOM, 0, '0, 1'b1, f));
        end else begin
          bkt_mem[wr_bucket][f] = it.element_in;
          bkt_fill[wr_bucket]   = f + 1;
          wr_pending--;
          due_results.push_back(res(ST_OK, 0, '0, 1'b1, f + 1));
        end
      end
      KIND_RELEASE: begin
        if (f > 0 && n_readable < NUM_BUCKETS) n_readable++;
        if (f < cap && n_writable < NUM_BUCKETS) n_writable++;
        bkt_busy[b] = 1'b0;
        due_results.push_back(res(ST_OK, 0, '0, 1'b1, f));
      end
      KIND_WR_BEGIN: begin
        room = (f < cap) ? cap - f : 0;
        if (room >= n) begin
          wr_pending = n;
          wr_bucket  = b;
          due_results.push_back(res(ST_OK, 0, '0, 1'b1, f));
        end else begin
          wr_pending = 0;
          due_results.push_back(res(ST_NO_ROOM, 0, '0, 1'b1, f));
        end
      end
      KIND_READ: begin
        if (n > MAX_RUN || n > f) begin
          due_results.push_back(res(ST_NO_DATA, 0, '0, 1'b1, f));
        end else if (n == 0) begin
          due_results.push_back(res(ST_OK, 0, '0, 1'b1, f));
        end else begin
          bkt_fill[b] = f - n;
          for (i = 0; i < n; i++) begin
            due_results.push_back(res(ST_OK, 0, bkt_mem[b][f - n + i], i + 1 == n, f - n));
          end
        end
      end
      default: begin
        due_results.push_back(res(ST_OK, 0, '0, 1'b1, f));
      end
    endcase
  endfunction

  function automatic in_t mk_item(logic [2:0] kind, int unsigned idx, int unsigned n);
    in_t it;
    it.kind         = kind;
    it.bucket_index = 3'(idx);
    it.item_count   = 5'(n);
    it.element_in   = $urandom;
    return it;
  endfunction

  // start_i stays high when the next transfer follows in the same step
  task automatic issue(in_t it, logic has_want = 1'b0, out_t want = '0);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    advance_pool(it);
    if (has_want) begin
      void'(due_results.pop_back());
      due_results.push_back(want);
    end
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (4 * NUM_BUCKETS) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [6:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    capacity = 32'(v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== 32'(v)) begin
      mismatches++;
      $display("%0t ns: capacity readback expected %0h, got %0h", $time, 32'(v), prdata);
    end
    n_settings++;
  endtask

  task automatic write_flow();
    int unsigned b, room, n, k, r;
    issue(mk_item(KIND_ACQ_WR, $urandom_range(0, 7), $urandom_range(0, 31)));
    b    = grant_ok ? grant_idx : $urandom_range(0, NUM_BUCKETS - 1);
    room = (eff_capacity() > bkt_fill[b]) ? eff_capacity() - bkt_fill[b] : 0;
    if (room > MAX_RUN) room = MAX_RUN;
    n = (room > 0) ? $urandom_range(1, room) : $urandom_range(1, 4);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 31);
    issue(mk_item(KIND_WR_BEGIN, b, n));
    k = n;
    r = $urandom_range(0, 7);
    if (r == 0) k = n + 1;
    else if (r == 1 && n > 0) k = n - 1;
    repeat (k) issue(mk_item(KIND_WR_DATA, $urandom_range(0, 7), $urandom_range(0, 31)));
    if ($urandom_range(0, 7) != 0) issue(mk_item(KIND_RELEASE, b, $urandom_range(0, 31)));
  endtask

  task automatic read_flow();
    int unsigned b, lim, n;
    issue(mk_item(KIND_ACQ_RD, $urandom_range(0, 7), $urandom_range(0, 31)));
    b   = grant_ok ? grant_idx : $urandom_range(0, NUM_BUCKETS - 1);
    lim = (bkt_fill[b] > MAX_RUN) ? MAX_RUN : bkt_fill[b];
    n   = (lim > 0) ? $urandom_range(1, lim) : $urandom_range(0, 31);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 31);
    issue(mk_item(KIND_READ, b, n));
    if ($urandom_range(0, 7) != 0) issue(mk_item(KIND_RELEASE, b, $urandom_range(0, 31)));
  endtask

  function automatic void field_err(string name, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result expected none, got %p", $time, result_o);
      end else begin
        head = due_results.pop_front();
        results_checked++;
        if (result_o.status !== head.status)
          field_err("status", 32'(head.status), 32'(result_o.status));
        if (result_o.granted_bucket !== head.granted_bucket)
          field_err("granted_bucket", 32'(head.granted_bucket), 32'(result_o.granted_bucket));
        if (result_o.element_out !== head.element_out)
          field_err("element_out", head.element_out, result_o.element_out);
        if (result_o.last !== head.last)
          field_err("last", 32'(head.last), 32'(result_o.last));
        if (result_o.items_held !== head.items_held)
          field_err("items_held", 32'(head.items_held), 32'(result_o.items_held));
      end
    end
  end

  initial begin
    logic [6:0]  cap_plan [6];
    int unsigned phase_end, pick, p, i;
    cap_plan = '{7'd1, 7'd127, 7'd0, 7'd5, CAP_RESET, 7'd64};
    for (i = 0; i < NUM_BUCKETS; i++) begin
      bkt_busy[i] = 1'b0;
      bkt_fill[i] = 0;
    end
    n_readable      = 0;
    n_writable      = NUM_BUCKETS;
    wr_pending      = 0;
    wr_bucket       = 0;
    capacity        = 32'(CAP_RESET);
    items_sent      = 0;
    results_checked = 0;
    mismatches      = 0;
    burst_left      = 0;
    n_settings      = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(dir_tab); i++)
      issue(dir_tab[i].item, dir_tab[i].has_want, dir_tab[i].want);

    for (p = 0; p < 6; p++) begin
      drain();
      set_capacity((p == 5) ? 7'($urandom_range(1, 64)) : cap_plan[p]);
      // a write still open across the capacity change
      issue(mk_item(KIND_WR_DATA, $urandom_range(0, 7), $urandom_range(0, 31)));
      phase_end = items_sent + 18;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) write_flow();
        else if (pick < 7) read_flow();
        else issue(mk_item(3'($urandom_range(0, 7)), $urandom_range(0, 7),
                           $urandom_range(0, 31)));
      end
    end
    drain();

    $display("Sent %0d transfers over %0d capacity settings, checked %0d results.",
             items_sent, n_settings, results_checked);
    $display("Directed corners, then random pool flows with bursts and gaps; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding.", due_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
